>>> hdl/led_blink_pattern_multiplexer_defines.svh
// Assertion macros used by the checker file.
`ifndef LED_BLINK_PATTERN_MULTIPLEXER_DEFINES_SVH
`define LED_BLINK_PATTERN_MULTIPLEXER_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define LBPM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lbpm check failed");

// Next-cycle implication, disabled while in reset.
`define LBPM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lbpm check failed");

`endif

>>> hdl/lbpm_pkg.sv
package lbpm_pkg;

    localparam int DRIVE_W = 3;

    typedef enum logic [2:0] {
        PAT_SOLID      = 3'd0,
        PAT_SLOW       = 3'd1,
        PAT_FAST       = 3'd2,
        PAT_DOUBLE     = 3'd3,
        PAT_FLASH      = 3'd4,
        PAT_LONG_FLASH = 3'd5
    } pattern_t;

    typedef enum logic [2:0] {
        REG_MUX_DWELL    = 3'd0,
        REG_SLOW_ON      = 3'd1,
        REG_SLOW_OFF     = 3'd2,
        REG_FAST_ON      = 3'd3,
        REG_FAST_OFF     = 3'd4,
        REG_FLASH        = 3'd5,
        REG_FLASH_LONG   = 3'd6,
        REG_DOUBLE_PAUSE = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [7:0]  mux_dwell_ms;
        logic [11:0] slow_on_ms;
        logic [11:0] slow_off_ms;
        logic [11:0] fast_on_ms;
        logic [11:0] fast_off_ms;
        logic [11:0] flash_ms;
        logic [11:0] flash_long_ms;
        logic [11:0] double_pause_ms;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        mux_dwell_ms:    8'd4,
        slow_on_ms:      12'd50,
        slow_off_ms:     12'd1950,
        fast_on_ms:      12'd100,
        fast_off_ms:     12'd400,
        flash_ms:        12'd1000,
        flash_long_ms:   12'd1500,
        double_pause_ms: 12'd1760
    };

    // Fixed double blink timing
    localparam logic [11:0] DBL_ON_MS  = 12'd60;
    localparam logic [11:0] DBL_OFF_MS = 12'd120;

    // True when at least two channels of the mask are set
    function automatic logic two_or_more(input logic [2:0] m);
        return (m[0] & m[1]) | (m[0] & m[2]) | (m[1] & m[2]);
    endfunction

endpackage

>>> hdl/led_blink_pattern_multiplexer.sv
// LED blink pattern multiplexer.
// Input channel (in_valid / in_stall): each beat is either a 1 ms tick
// (command = 0) or a set request (command = 1) carrying led_mask and pattern.
// Output channel (out_valid / out_stall): exactly one beat per input beat,
// carrying drive, the channel outputs after that beat.
// Config: APB-style port, pready tied high, eight registers at byte addresses
// 0x00..0x1C, written by the user only while idle; not enforced by the block.
// Results: each result is registered in the result register or the skid entry.
// Throughput: one beat per cycle unless stalled; the whole state update is one
// short combinational pass from the state registers into the result buffer.
// Stall: the result register plus one skid entry absorb a stalled receiver;
// in_stall rises once both are occupied and falls as soon as the receiver
// takes a beat.
// Reset (rst_n low, async): all timing registers return to defaults, colour is
// cleared, pattern is solid, both timers idle, and the output buffer is empty.
module led_blink_pattern_multiplexer
    import lbpm_pkg::*;
#(
    parameter int CHANNELS   = 3,
    parameter int TIMER_BITS = 12
)
(
    input  logic               clk,
    input  logic               rst_n,
    // config port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // input beats
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               command,
    input  logic [2:0]         led_mask,
    input  logic [2:0]         pattern,
    // output beats
    output logic               out_valid,
    input  logic               out_stall,
    output logic [DRIVE_W-1:0] drive
);

    cfg_t               cfg;
    logic               accept;
    logic               buf_full;
    logic [DRIVE_W-1:0] drive_res;

    // take a beat whenever the skid entry is free
    assign in_stall = buf_full;
    assign accept   = in_valid && !buf_full;

    lbpm_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // state registers and single-pass next-state logic
    lbpm_core #(
        .CHANNELS   (CHANNELS),
        .TIMER_BITS (TIMER_BITS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .accept      (accept),
        .command     (command),
        .led_mask    (led_mask),
        .pattern     (pattern),
        .drive_res   (drive_res)
    );

    // result register with one skid entry
    lbpm_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (drive_res),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .drive     (drive)
    );

endmodule

>>> hdl/lbpm_cfg.sv
module lbpm_cfg
    import lbpm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t     cfg_reg;
    cfg_idx_t idx;
    logic     wr_en;

    assign idx    = cfg_idx_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_MUX_DWELL:    cfg_reg.mux_dwell_ms    <= pwdata[7:0];
                REG_SLOW_ON:      cfg_reg.slow_on_ms      <= pwdata[11:0];
                REG_SLOW_OFF:     cfg_reg.slow_off_ms     <= pwdata[11:0];
                REG_FAST_ON:      cfg_reg.fast_on_ms      <= pwdata[11:0];
                REG_FAST_OFF:     cfg_reg.fast_off_ms     <= pwdata[11:0];
                REG_FLASH:        cfg_reg.flash_ms        <= pwdata[11:0];
                REG_FLASH_LONG:   cfg_reg.flash_long_ms   <= pwdata[11:0];
                REG_DOUBLE_PAUSE: cfg_reg.double_pause_ms <= pwdata[11:0];
                default:          cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_MUX_DWELL:    prdata = 32'(cfg_reg.mux_dwell_ms);
            REG_SLOW_ON:      prdata = 32'(cfg_reg.slow_on_ms);
            REG_SLOW_OFF:     prdata = 32'(cfg_reg.slow_off_ms);
            REG_FAST_ON:      prdata = 32'(cfg_reg.fast_on_ms);
            REG_FAST_OFF:     prdata = 32'(cfg_reg.fast_off_ms);
            REG_FLASH:        prdata = 32'(cfg_reg.flash_ms);
            REG_FLASH_LONG:   prdata = 32'(cfg_reg.flash_long_ms);
            REG_DOUBLE_PAUSE: prdata = 32'(cfg_reg.double_pause_ms);
            default:          prdata = '0;
        endcase
    end

endmodule

>>> hdl/lbpm_core.sv
module lbpm_core
    import lbpm_pkg::*;
#(
    parameter int CHANNELS   = 3,
    parameter int TIMER_BITS = 12
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               accept,
    input  logic               command,
    input  logic [2:0]         led_mask,
    input  logic [2:0]         pattern,
    output logic [DRIVE_W-1:0] drive_res
);

    localparam int                  LW      = (TIMER_BITS > 12) ? TIMER_BITS : 12;
    localparam logic [TIMER_BITS-1:0] Tmax  = '1;
    localparam logic [2:0]          ChMask  = 3'((1 << CHANNELS) - 1);
    localparam logic [1:0]          LastCh  = 2'(CHANNELS - 1);

    // double blink sub-steps
    localparam logic [1:0] DS_ON_FIRST  = 2'd0;
    localparam logic [1:0] DS_GAP       = 2'd1;
    localparam logic [1:0] DS_ON_SECOND = 2'd2;
    localparam logic [1:0] DS_PAUSE     = 2'd3;

    logic [2:0]            colour_reg,      colour_next;
    pattern_t              mode_reg,        mode_next;
    logic                  phase_lit_reg,   phase_lit_next;
    logic [TIMER_BITS-1:0] phase_count_reg, phase_count_next;
    logic [1:0]            double_step_reg, double_step_next;
    logic [7:0]            mux_count_reg,   mux_count_next;
    logic [1:0]            mux_channel_reg, mux_channel_next;

    pattern_t   pat_sel;
    logic [2:0] colour_set;
    logic [2:0] lit_cur;
    logic [2:0] lit_new;
    logic [7:0] dwell_load;
    logic       phase_hit;
    logic       mux_hit;

    // zero loads as 1, oversize saturates
    function automatic logic [TIMER_BITS-1:0] timer_load(input logic [11:0] v);
        logic [LW-1:0] ext;
        ext = LW'(v);
        if (v == 12'd0)
            return TIMER_BITS'(1);
        else if (ext > LW'(Tmax))
            return Tmax;
        else
            return TIMER_BITS'(ext);
    endfunction

    // next set channel after ch, wrapping at CHANNELS
    function automatic logic [1:0] next_channel(input logic [2:0] m, input logic [1:0] ch);
        logic [1:0] cur;
        logic [1:0] res;
        logic       found;
        cur   = ch;
        res   = ch;
        found = 1'b0;
        for (int k = 0; k < CHANNELS; k++)
        begin
            cur = (cur == LastCh) ? 2'd0 : cur + 2'd1;
            if (!found && m[cur])
            begin
                res   = cur;
                found = 1'b1;
            end
        end
        return res;
    endfunction

    assign pat_sel    = (pattern > 3'd5) ? PAT_SOLID : pattern_t'(pattern);
    assign colour_set = led_mask & ChMask;
    assign lit_cur    = phase_lit_reg ? colour_reg : 3'd0;
    assign dwell_load = (cfg.mux_dwell_ms == 8'd0) ? 8'd1 : cfg.mux_dwell_ms;
    assign phase_hit  = (phase_count_reg == TIMER_BITS'(1));
    assign mux_hit    = (mux_count_reg == 8'd1);

    always_comb
    begin
        colour_next      = colour_reg;
        mode_next        = mode_reg;
        phase_lit_next   = phase_lit_reg;
        phase_count_next = phase_count_reg;
        double_step_next = double_step_reg;
        mux_count_next   = mux_count_reg;
        mux_channel_next = mux_channel_reg;

        if (accept && command)
        begin
            colour_next      = colour_set;
            mode_next        = pat_sel;
            double_step_next = DS_ON_FIRST;
            phase_lit_next   = (colour_set != 3'd0);
            if (two_or_more(colour_set))
            begin
                mux_channel_next = next_channel(colour_set, mux_channel_reg);
                mux_count_next   = dwell_load;
            end
            else
            begin
                mux_count_next = 8'd0;
            end
            phase_count_next = '0;
            if (colour_set != 3'd0)
            begin
                case (pat_sel)
                    PAT_SLOW:       phase_count_next = timer_load(cfg.slow_on_ms);
                    PAT_FAST:       phase_count_next = timer_load(cfg.fast_on_ms);
                    PAT_DOUBLE:     phase_count_next = timer_load(DBL_ON_MS);
                    PAT_FLASH:      phase_count_next = timer_load(cfg.flash_ms);
                    PAT_LONG_FLASH: phase_count_next = timer_load(cfg.flash_long_ms);
                    default:        phase_count_next = '0;
                endcase
            end
        end
        else if (accept)
        begin
            // tick: both counters count down first
            if (phase_count_reg != '0)
                phase_count_next = phase_count_reg - TIMER_BITS'(1);
            if (mux_count_reg != 8'd0)
                mux_count_next = mux_count_reg - 8'd1;

            if (phase_hit)
            begin
                phase_count_next = '0;
                case (mode_reg) inside
                    PAT_SLOW:
                    begin
                        phase_lit_next   = !phase_lit_reg;
                        phase_count_next = timer_load(phase_lit_reg ? cfg.slow_off_ms
                                                                    : cfg.slow_on_ms);
                    end
                    PAT_FAST:
                    begin
                        phase_lit_next   = !phase_lit_reg;
                        phase_count_next = timer_load(phase_lit_reg ? cfg.fast_off_ms
                                                                    : cfg.fast_on_ms);
                    end
                    PAT_DOUBLE:
                    begin
                        double_step_next = double_step_reg + 2'd1;
                        case (double_step_next)
                            DS_ON_FIRST, DS_ON_SECOND:
                            begin
                                phase_lit_next   = 1'b1;
                                phase_count_next = timer_load(DBL_ON_MS);
                            end
                            DS_GAP:
                            begin
                                phase_lit_next   = 1'b0;
                                phase_count_next = timer_load(DBL_OFF_MS);
                            end
                            DS_PAUSE:
                            begin
                                phase_lit_next   = 1'b0;
                                phase_count_next = timer_load(cfg.double_pause_ms);
                            end
                            default:
                            begin
                                phase_lit_next = 1'b0;
                            end
                        endcase
                    end
                    PAT_FLASH, PAT_LONG_FLASH:
                    begin
                        phase_lit_next = 1'b0;
                        colour_next    = 3'd0;
                    end
                    default:
                    begin
                        phase_lit_next = 1'b1;
                    end
                endcase

                // refresh overrides any mux expiry this tick
                if (two_or_more(phase_lit_next ? colour_next : 3'd0))
                begin
                    mux_channel_next = next_channel(colour_next, mux_channel_reg);
                    mux_count_next   = dwell_load;
                end
                else
                begin
                    mux_count_next = 8'd0;
                end
            end
            else if (mux_hit && two_or_more(lit_cur))
            begin
                mux_channel_next = next_channel(lit_cur, mux_channel_reg);
                mux_count_next   = dwell_load;
            end
        end
    end

    assign lit_new   = phase_lit_next ? colour_next : 3'd0;
    assign drive_res = two_or_more(lit_new) ? (3'b001 << mux_channel_next) : lit_new;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            colour_reg      <= '0;
            mode_reg        <= PAT_SOLID;
            phase_lit_reg   <= 1'b0;
            phase_count_reg <= '0;
            double_step_reg <= '0;
            mux_count_reg   <= '0;
            mux_channel_reg <= '0;
        end
        else
        begin
            colour_reg      <= colour_next;
            mode_reg        <= mode_next;
            phase_lit_reg   <= phase_lit_next;
            phase_count_reg <= phase_count_next;
            double_step_reg <= double_step_next;
            mux_count_reg   <= mux_count_next;
            mux_channel_reg <= mux_channel_next;
        end
    end

endmodule

>>> hdl/lbpm_obuf.sv
module lbpm_obuf
    import lbpm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic [DRIVE_W-1:0] push_data,
    output logic               full,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [DRIVE_W-1:0] drive
);

    logic               main_valid_reg, main_valid_next;
    logic               skid_valid_reg, skid_valid_next;
    logic [DRIVE_W-1:0] main_data_reg,  main_data_next;
    logic [DRIVE_W-1:0] skid_data_reg,  skid_data_next;
    logic               pop;

    assign pop       = main_valid_reg && !out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign drive     = main_data_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        main_data_next  = main_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;

        if (!main_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                main_data_next  = skid_data_reg;
                main_valid_next = 1'b1;
                skid_valid_next = push;
                skid_data_next  = push_data;
            end
            else
            begin
                main_data_next  = push_data;
                main_valid_next = push;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

>>> hdl/lbpm_checker.sv
`include "led_blink_pattern_multiplexer_defines.svh"

module lbpm_checker
    import lbpm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic               command,
    input  logic [2:0]         led_mask,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [DRIVE_W-1:0] drive
);

    logic set_dark;

    // empty set request taken while the output is idle
    assign set_dark = in_valid && !in_stall && command && (led_mask == 3'd0) && !out_valid;

    // never more than one channel driven at a time
    `LBPM_ASSERT_NOW(a_drive_single, out_valid, $onehot0(drive))

    // input side only backs up when a result is waiting
    `LBPM_ASSERT_NOW(a_stall_needs_result, in_stall, out_valid)

    // an empty set request on an idle output turns everything off next cycle
    `LBPM_ASSERT_NEXT(a_clear_dark, set_dark, out_valid && drive == 3'd0)

    // stalled result holds
    `LBPM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(drive))

endmodule

bind led_blink_pattern_multiplexer lbpm_checker u_lbpm_checker (.*);

>>> dv/tb_led_blink_pattern_multiplexer.sv
`timescale 1ns / 100ps

module tb_led_blink_pattern_multiplexer
    import lbpm_pkg::*;
();

    // Beat kinds on the input channel
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_SET  = 1'b1;

    // Pattern codes beyond the defined set; the block stores them as solid
    localparam logic [2:0] PAT_SPARE_6 = 3'd6;
    localparam logic [2:0] PAT_SPARE_7 = 3'd7;

    localparam int NUM_CH = 3;

    // How a side spaces its beats
    localparam int IDLE_NONE   = 0;
    localparam int IDLE_RANDOM = 1;
    localparam int IDLE_SPARSE = 2;

    // Long receiver hold-offs, keyed on the count of drive beats taken so far
    localparam int HOLD_LEN  = 200;
    localparam int HOLD_AT_A = 150;
    localparam int HOLD_AT_B = 1100;

    typedef struct packed {
        logic       cmd;
        logic [2:0] mask;
        logic [2:0] pat;
    } led_beat_t;

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               psel        = 1'b0;
    logic               penable     = 1'b0;
    logic               pwrite      = 1'b0;
    logic [4:0]         paddr       = '0;
    logic [31:0]        pwdata      = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid    = 1'b0;
    logic               in_stall;
    logic               command     = 1'b0;
    logic [2:0]         led_mask    = '0;
    logic [2:0]         pattern     = '0;
    logic               out_valid;
    logic               out_stall   = 1'b0;
    logic [DRIVE_W-1:0] drive;

    led_blink_pattern_multiplexer u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .led_mask    (led_mask),
        .pattern     (pattern),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .drive       (drive)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Lamp predictor: colour, pattern, blink phase, the two countdowns and
    // the multiplexer position, with the register values now in force.
    // ------------------------------------------------------------------
    cfg_t        cfg_now     = CFG_RESET;
    logic [2:0]  lamp_colour = '0;
    pattern_t    lamp_mode   = PAT_SOLID;
    logic        lamp_lit    = 1'b0;
    logic [11:0] phase_left  = '0;
    logic [1:0]  dbl_step    = '0;
    logic [7:0]  dwell_left  = '0;
    logic [1:0]  mux_ch      = '0;

    // Timer loads: zero counts as one tick; 12-bit registers cannot exceed the counter
    function automatic logic [11:0] load_ticks(input logic [11:0] v);
        return (v == 12'd0) ? 12'd1 : v;
    endfunction

    function automatic logic [2:0] lit_now();
        return lamp_lit ? lamp_colour : 3'b000;
    endfunction

    // Move to the next lit channel and restart the dwell
    function automatic void mux_step();
        logic [2:0] lit;
        int         ch;
        int         k;
        bit         found;
        lit   = lit_now();
        ch    = mux_ch;
        found = 1'b0;
        for (k = 0; k < NUM_CH; k++) begin
            if (!found) begin
                ch    = (ch + 1) % NUM_CH;
                found = lit[ch];
            end
        end
        mux_ch     = 2'(ch);
        dwell_left = (cfg_now.mux_dwell_ms != 8'd0) ? cfg_now.mux_dwell_ms : 8'd1;
    endfunction

    // Fewer than two lit channels: multiplexer idles, output static
    function automatic void mux_refresh();
        if ($countones(lit_now()) < 2)
            dwell_left = '0;
        else
            mux_step();
    endfunction

    // Apply one accepted beat and return the drive it should produce
    function automatic logic [2:0] lamp_step(input led_beat_t b);
        logic       phase_due;
        logic       dwell_due;
        logic [2:0] lit;
        if (b.cmd == CMD_SET) begin
            lamp_colour = b.mask;
            lamp_mode   = (b.pat > PAT_LONG_FLASH) ? PAT_SOLID : pattern_t'(b.pat);
            dbl_step    = 2'd0;
            lamp_lit    = (lamp_colour != 3'b000);
            mux_refresh();
            phase_left  = '0;
            if (lamp_colour != 3'b000) begin
                case (lamp_mode)
                    PAT_SLOW:       phase_left = load_ticks(cfg_now.slow_on_ms);
                    PAT_FAST:       phase_left = load_ticks(cfg_now.fast_on_ms);
                    PAT_DOUBLE:     phase_left = load_ticks(DBL_ON_MS);
                    PAT_FLASH:      phase_left = load_ticks(cfg_now.flash_ms);
                    PAT_LONG_FLASH: phase_left = load_ticks(cfg_now.flash_long_ms);
                    default:        ;
                endcase
            end
        end else begin
            // both counters step first; a phase event outranks a dwell expiry
            phase_due = 1'b0;
            dwell_due = 1'b0;
            if (phase_left != 12'd0) begin
                phase_left = phase_left - 12'd1;
                phase_due  = (phase_left == 12'd0);
            end
            if (dwell_left != 8'd0) begin
                dwell_left = dwell_left - 8'd1;
                dwell_due  = (dwell_left == 8'd0);
            end
            if (phase_due) begin
                case (lamp_mode)
                    PAT_SLOW: begin
                        lamp_lit   = ~lamp_lit;
                        phase_left = load_ticks(lamp_lit ? cfg_now.slow_on_ms
                                                         : cfg_now.slow_off_ms);
                    end
                    PAT_FAST: begin
                        lamp_lit   = ~lamp_lit;
                        phase_left = load_ticks(lamp_lit ? cfg_now.fast_on_ms
                                                         : cfg_now.fast_off_ms);
                    end
                    PAT_DOUBLE: begin
                        // on 60, off 120, on 60, long pause
                        dbl_step = dbl_step + 2'd1;
                        case (dbl_step)
                            2'd0, 2'd2: begin
                                lamp_lit   = 1'b1;
                                phase_left = load_ticks(DBL_ON_MS);
                            end
                            2'd1: begin
                                lamp_lit   = 1'b0;
                                phase_left = load_ticks(DBL_OFF_MS);
                            end
                            default: begin
                                lamp_lit   = 1'b0;
                                phase_left = load_ticks(cfg_now.double_pause_ms);
                            end
                        endcase
                    end
                    PAT_FLASH, PAT_LONG_FLASH: begin
                        // one-shot over: colour goes dark for good
                        lamp_lit    = 1'b0;
                        lamp_colour = 3'b000;
                    end
                    default: lamp_lit = 1'b1;
                endcase
                mux_refresh();
            end else if (dwell_due && $countones(lit_now()) >= 2) begin
                mux_step();
            end
        end
        lit = lit_now();
        return ($countones(lit) >= 2) ? (3'b001 << mux_ch) : lit;
    endfunction

    // ------------------------------------------------------------------
    // Shared bookkeeping
    // ------------------------------------------------------------------
    led_beat_t  beat_q[$];           // beats waiting to be offered
    logic [2:0] pending_drive_q[$];  // predicted drive, oldest first
    int         beats_queued   = 0;
    int         beats_sent     = 0;
    int         beats_seen     = 0;
    int         fail_count     = 0;
    int         stalled_offers = 0;
    int         holds_done     = 0;
    int         tx_style       = IDLE_RANDOM;
    int         rx_style       = IDLE_RANDOM;
    int         gap_left       = 0;
    int         rx_wait        = 0;

    function automatic int draw_wait(input int style);
        case (style)
            IDLE_NONE:   return 0;
            IDLE_RANDOM: return $urandom_range(0, 13);
            default:     return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 13) : 0;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Sender: offers queued beats, holds the payload while stalled, and
    // predicts each beat at the edge where it is taken.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin : feed_p
        led_beat_t nxt;
        if (!rst_n) begin
            in_valid <= 1'b0;
            gap_left <= 0;
        end else begin
            if (in_valid && in_stall)
                stalled_offers++;
            if (in_valid && !in_stall) begin
                pending_drive_q.push_back(
                    lamp_step(led_beat_t'({command, led_mask, pattern})));
                beats_sent++;
            end
            if (!in_valid || !in_stall) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end else if (beat_q.size() != 0) begin
                    nxt = beat_q.pop_front();
                    command     <= nxt.cmd;
                    led_mask    <= nxt.mask;
                    pattern     <= nxt.pat;
                    in_valid    <= 1'b1;
                    // idle time before the beat after this one
                    gap_left    <= draw_wait(tx_style);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: checks every drive beat against the oldest prediction and
    // stalls at random. Twice it makes a long hold-off so the result
    // buffer and skid entry fill and in_stall must rise.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin : take_p
        logic       fire;
        logic [2:0] want;
        int         w;
        if (!rst_n) begin
            out_stall <= 1'b0;
            rx_wait   <= 0;
        end else begin
            fire = out_valid && !out_stall;
            if (fire) begin
                beats_seen++;
                if (pending_drive_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("drive beat %0d arrived with nothing expected: %b",
                                 beats_seen, drive);
                end else begin
                    want = pending_drive_q.pop_front();
                    if (drive !== want) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("drive mismatch at beat %0d: expected %b, got %b",
                                     beats_seen, want, drive);
                    end
                end
            end
            if (fire && (beats_seen == HOLD_AT_A || beats_seen == HOLD_AT_B)) begin
                holds_done++;
                out_stall <= 1'b1;
                rx_wait   <= HOLD_LEN - 1;
            end else if (fire) begin
                w = draw_wait(rx_style);
                out_stall <= (w != 0);
                rx_wait   <= (w != 0) ? w - 1 : 0;
            end else if (rx_wait != 0) begin
                rx_wait <= rx_wait - 1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_beat(input logic cmd, input logic [2:0] mask,
                             input logic [2:0] pat);
        led_beat_t b;
        b.cmd  = cmd;
        b.mask = mask;
        b.pat  = pat;
        beat_q.push_back(b);
        beats_queued++;
    endtask

    // ticks carry random filler in the unused fields
    task automatic push_ticks(input int n);
        repeat (n) push_beat(CMD_TICK, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
    endtask

    // Mostly a set request followed by a run of ticks, some back-to-back
    // requests and lone ticks as noise.
    task automatic queue_random(input int target, input int tick_max);
        int start;
        int r;
        start = beats_queued;
        while (beats_queued - start < target) begin
            r = $urandom_range(0, 9);
            if (r < 7) begin
                push_beat(CMD_SET, 3'($urandom_range(0, 7)),
                          ($urandom_range(0, 9) < 8) ? 3'($urandom_range(1, 5))
                                                     : 3'($urandom_range(0, 7)));
                push_ticks($urandom_range(1, ($urandom_range(0, 3) == 0) ? tick_max : 16));
            end else if (r < 9) begin
                push_beat(CMD_SET, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
            end else begin
                push_ticks(1);
            end
        end
    endtask

    // Wait until every queued beat has been taken and its drive checked
    task automatic settle();
        while (beats_sent != beats_queued || beats_seen != beats_queued)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // APB write: setup cycle, then access cycle; pready is always high
    task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Waits for the block to drain before writing
    task automatic load_cfg(input cfg_t c);
        settle();
        write_reg(REG_MUX_DWELL,    32'(c.mux_dwell_ms));
        write_reg(REG_SLOW_ON,      32'(c.slow_on_ms));
        write_reg(REG_SLOW_OFF,     32'(c.slow_off_ms));
        write_reg(REG_FAST_ON,      32'(c.fast_on_ms));
        write_reg(REG_FAST_OFF,     32'(c.fast_off_ms));
        write_reg(REG_FLASH,        32'(c.flash_ms));
        write_reg(REG_FLASH_LONG,   32'(c.flash_long_ms));
        write_reg(REG_DOUBLE_PAUSE, 32'(c.double_pause_ms));
        cfg_now = c;
    endtask

    function automatic cfg_t flat_cfg(input logic [7:0] dwell, input logic [11:0] t);
        cfg_t c;
        c.mux_dwell_ms    = dwell;
        c.slow_on_ms      = t;
        c.slow_off_ms     = t;
        c.fast_on_ms      = t;
        c.fast_off_ms     = t;
        c.flash_ms        = t;
        c.flash_long_ms   = t;
        c.double_pause_ms = t;
        return c;
    endfunction

    function automatic cfg_t random_cfg(input int dwell_max, input int t_max);
        cfg_t c;
        c.mux_dwell_ms    = 8'($urandom_range(1, dwell_max));
        c.slow_on_ms      = 12'($urandom_range(1, t_max));
        c.slow_off_ms     = 12'($urandom_range(1, t_max));
        c.fast_on_ms      = 12'($urandom_range(1, t_max));
        c.fast_off_ms     = 12'($urandom_range(1, t_max));
        c.flash_ms        = 12'($urandom_range(1, t_max));
        c.flash_long_ms   = 12'($urandom_range(1, t_max));
        c.double_pause_ms = 12'($urandom_range(1, t_max));
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : stim_p
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed, at reset register values (dwell 4)
        push_beat(CMD_SET, 3'b111, PAT_SOLID);     // three lit channels, multiplexed
        push_ticks(5);                              // dwell rotation
        push_beat(CMD_SET, 3'b001, PAT_SPARE_6);   // unknown code stored as solid
        push_ticks(1);
        push_beat(CMD_SET, 3'b000, PAT_SLOW);      // empty colour: no timer
        push_ticks(1);
        push_beat(CMD_SET, 3'b110, PAT_FAST);      // two channels, blinking
        push_ticks(3);
        push_beat(CMD_SET, 3'b101, PAT_DOUBLE);
        push_ticks(2);
        push_beat(CMD_SET, 3'b010, PAT_FLASH);
        push_ticks(1);
        push_beat(CMD_SET, 3'b011, PAT_LONG_FLASH);
        push_ticks(1);
        push_beat(CMD_SET, 3'b100, PAT_SPARE_7);
        push_ticks(1);
        push_beat(CMD_SET, 3'b000, PAT_SOLID);

        // Floor: every timer and the dwell at one tick, so phase and dwell
        // expire in the same tick again and again. First long hold lands here.
        load_cfg(flat_cfg(8'd1, 12'd1));
        tx_style = IDLE_SPARSE;
        rx_style = IDLE_RANDOM;
        queue_random(300, 12);

        // All registers zero: loaded as one tick
        load_cfg(flat_cfg(8'd0, 12'd0));
        tx_style = IDLE_NONE;
        rx_style = IDLE_NONE;
        queue_random(200, 12);

        // Short random timings; long tick runs walk the double blink through
        load_cfg(random_cfg(8, 20));
        tx_style = IDLE_RANDOM;
        rx_style = IDLE_SPARSE;
        queue_random(500, 300);

        // Ceiling: dwell 255, timers full scale
        load_cfg(flat_cfg(8'd255, 12'hFFF));
        tx_style = IDLE_SPARSE;
        rx_style = IDLE_NONE;
        queue_random(250, 250);

        // Mid-range random timings, any dwell
        load_cfg(random_cfg(255, 200));
        tx_style = IDLE_RANDOM;
        rx_style = IDLE_RANDOM;
        queue_random(500, 400);

        // Back to the power-on values
        load_cfg(CFG_RESET);
        tx_style = IDLE_NONE;
        rx_style = IDLE_SPARSE;
        queue_random(100, 100);

        settle();
        repeat (8) @(negedge clk);
        fail_count += pending_drive_q.size();

        $display("Checked %0d drive beats across six timing settings (floor, zero, ceiling,",
                 beats_seen);
        $display("random, reset); %0d long receiver holds, %0d cycles with input held off.",
                 holds_done, stalled_offers);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin : watchdog_p
        #3_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> led_blink_pattern_multiplexer.f
+incdir+hdl
hdl/lbpm_pkg.sv
hdl/lbpm_cfg.sv
hdl/lbpm_core.sv
hdl/lbpm_obuf.sv
hdl/led_blink_pattern_multiplexer.sv
hdl/lbpm_checker.sv
dv/tb_led_blink_pattern_multiplexer.sv
